// File: rtl/gsts_pkg.sv
package gsts_pkg;

    localparam int NUM_GROUPS = 4;
    localparam int SLOTS      = 16;
    localparam int TIME_WIDTH = 32;
    localparam int GW         = 2;
    localparam int SW         = 4;
    localparam int CW         = 5;

    localparam logic [CW-1:0] NONE_SLOT = CW'(SLOTS);

    typedef enum logic [2:0] {
        REQ_CREATE  = 3'd0,
        REQ_QUEUE   = 3'd1,
        REQ_PROCESS = 3'd2,
        REQ_ENABLE  = 3'd3,
        REQ_REMOVE  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ABSENT   = 3'd1,
        ST_FULL     = 3'd2,
        ST_DISABLED = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CFG_ENABLE = 3'd0,
        CFG_CAP0   = 3'd1,
        CFG_CAP1   = 3'd2,
        CFG_CAP2   = 3'd3,
        CFG_CAP3   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } fsm_t;

    // One slot's contents, rotating along the row of cells.
    typedef struct packed {
        logic                  used;
        logic                  periodic;
        logic                  enabled;
        logic                  remove;
        logic [TIME_WIDTH-1:0] due;
        logic [TIME_WIDTH-1:0] period;
    } slot_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic                  shift;
        logic [GW-1:0]         grp;
        logic                  wr_new;
        logic                  wr_periodic;
        logic                  wr_en;
        logic                  en_value;
        logic                  wr_rem;
        logic                  fire;
        logic [TIME_WIDTH-1:0] now;
        logic [TIME_WIDTH-1:0] ivl;
    } cell_cmd_t;

endpackage

// File: rtl/gsts_if.sv
interface gsts_req_if;
    import gsts_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [2:0]            req_type;
    logic [1:0]            group_index;
    logic [3:0]            target_slot;
    logic [TIME_WIDTH-1:0] now_ms;
    logic [TIME_WIDTH-1:0] interval_ms;
    logic                  enable_value;
    modport source (output valid, req_type, group_index, target_slot, now_ms,
                    interval_ms, enable_value, input ready);
    modport sink (input valid, req_type, group_index, target_slot, now_ms,
                  interval_ms, enable_value, output ready);
endinterface

interface gsts_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] result_slot;
    logic       fired;
    logic [4:0] current_slot;
    logic       last;
    modport source (output valid, status, result_slot, fired, current_slot, last,
                    input ready);
    modport sink (input valid, status, result_slot, fired, current_slot, last,
                  output ready);
endinterface

// File: rtl/gsts_cell.sv
// One slot of every group. Each cell passes a group's slot to the cell before it
// when that group's ring rotates, so the head cell always holds the slot under inspection.
module gsts_cell
    import gsts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      is_head,
    input  slot_t     prev_slot [NUM_GROUPS],
    output slot_t     slot      [NUM_GROUPS]
);

    logic [NUM_GROUPS-1:0] used_reg, enabled_reg, remove_reg;
    logic [NUM_GROUPS-1:0] periodic_reg;
    logic [TIME_WIDTH-1:0] due_reg    [NUM_GROUPS];
    logic [TIME_WIDTH-1:0] period_reg [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            slot[g].used     = used_reg[g];
            slot[g].periodic = periodic_reg[g];
            slot[g].enabled  = enabled_reg[g];
            slot[g].remove   = remove_reg[g];
            slot[g].due      = due_reg[g];
            slot[g].period   = period_reg[g];
        end
    end

    // Control bits: rotate, or update when this is the head cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            enabled_reg <= '0;
            remove_reg  <= '0;
        end
        else
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                if (cmd.shift && GW'(g) == cmd.grp)
                begin
                    used_reg[g]    <= prev_slot[g].used;
                    enabled_reg[g] <= prev_slot[g].enabled;
                    remove_reg[g]  <= prev_slot[g].remove;
                end
                else if (is_head && GW'(g) == cmd.grp)
                begin
                    if (cmd.wr_new)
                    begin
                        used_reg[g]    <= 1'b1;
                        remove_reg[g]  <= 1'b0;
                        enabled_reg[g] <= !cmd.wr_periodic;
                    end
                    if (cmd.wr_en)
                        enabled_reg[g] <= cmd.en_value;
                    if (cmd.wr_rem)
                        remove_reg[g] <= 1'b1;
                    if (cmd.fire && (!periodic_reg[g] || remove_reg[g]))
                        used_reg[g] <= 1'b0;
                end
            end
        end
    end

    // Payload: times and kind.
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (cmd.shift && GW'(g) == cmd.grp)
            begin
                periodic_reg[g] <= prev_slot[g].periodic;
                due_reg[g]      <= prev_slot[g].due;
                period_reg[g]   <= prev_slot[g].period;
            end
            else if (is_head && GW'(g) == cmd.grp)
            begin
                if (cmd.wr_new)
                begin
                    periodic_reg[g] <= cmd.wr_periodic;
                    period_reg[g]   <= cmd.ivl;
                    due_reg[g]      <= cmd.wr_periodic ? '0 : cmd.now + cmd.ivl;
                end
                if (cmd.fire && periodic_reg[g])
                    due_reg[g] <= cmd.now + period_reg[g];
            end
        end
    end

endmodule

// File: rtl/gsts_row.sv
// Ring of cells. Rotation of one group brings the slot at position pos+1 to
// the head; the controller tracks the position.
module gsts_row
    import gsts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    output slot_t     head [NUM_GROUPS]
);

    slot_t cs [SLOTS][NUM_GROUPS];

    for (genvar c = 0; c < SLOTS; c++)
    begin : g_cell
        gsts_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .is_head   (c == 0),
            .prev_slot (cs[(c + 1) % SLOTS]),
            .slot      (cs[c])
        );
    end

    assign head = cs[0];

endmodule

// File: rtl/gsts_ctrl.sv
// Sequencer: rotates the addressed group's ring once around per request that
// passes the entry checks, acting at the head cell when the wanted slot passes.
module gsts_ctrl
    import gsts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  slot_t     head [NUM_GROUPS],
    output cell_cmd_t cmd,
    gsts_req_if.sink   req,
    gsts_res_if.source res
);

    fsm_t state_reg, state_next;
    logic            proc_en_reg;
    logic [CW-1:0]   cap_reg [NUM_GROUPS];
    logic [CW-1:0]   last_reg [NUM_GROUPS];
    logic [GW-1:0]   grp_reg;
    logic [2:0]      type_reg;
    logic [SW-1:0]   tgt_reg;
    logic [TIME_WIDTH-1:0] now_reg, ivl_reg;
    logic            en_reg;
    logic [CW-1:0]   cnt_reg;
    logic [SW-1:0]   pos_reg [NUM_GROUPS];
    logic            done_reg;
    logic [CW-1:0]   found_reg;

    logic            ov_reg;
    logic [2:0]      ost_reg;
    logic [CW-1:0]   oslot_reg, ocur_reg;
    logic            ofired_reg, olast_reg;

    logic [CW-1:0] cap_sat, cap_in, cur_in;
    slot_t         h;
    logic          accept, res_free, at_end, hit, in_cap;
    logic [CW-1:0] pos_ext;

    assign res_free = !ov_reg || res.ready;
    assign accept   = req.valid && req.ready;
    assign h        = head[grp_reg];
    assign cap_sat  = cap_reg[grp_reg] > CW'(SLOTS) ? CW'(SLOTS) : cap_reg[grp_reg];
    assign cap_in   = cap_reg[req.group_index] > CW'(SLOTS) ? CW'(SLOTS)
                                                             : cap_reg[req.group_index];
    assign cur_in   = cap_in != '0 ? last_reg[req.group_index] : NONE_SLOT;
    assign pos_ext  = CW'(pos_reg[grp_reg]);
    assign in_cap   = pos_ext < cap_sat;
    assign at_end   = cnt_reg == CW'(SLOTS - 1);

    // Next state. The scan ends only on the shift that completes the turn.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept && req.req_type <= REQ_REMOVE && cap_in != '0
                    && !(req.req_type == REQ_PROCESS && !proc_en_reg))
                    state_next = S_SCAN;
            S_SCAN:
                if (at_end && cmd.shift)
                    state_next = S_OUT;
            S_OUT:
                if (res_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Whether the head slot triggers a result this cycle.
    always_comb
    begin
        hit = 1'b0;
        if (state_reg == S_SCAN && in_cap && !done_reg)
        begin
            unique case (req_t'(type_reg))
                REQ_CREATE, REQ_QUEUE: hit = 1'b0;
                REQ_ENABLE, REQ_REMOVE: hit = 1'b0;
                REQ_PROCESS: hit = h.used && h.enabled && now_reg >= h.due;
                default: hit = 1'b0;
            endcase
        end
    end

    // Cell command outputs.
    always_comb
    begin
        cmd = '0;
        cmd.grp = grp_reg;
        cmd.now = now_reg;
        cmd.ivl = ivl_reg;
        cmd.en_value = en_reg;
        cmd.wr_periodic = type_reg == REQ_CREATE;
        if (state_reg == S_SCAN)
        begin
            cmd.shift = !hit || res_free ? !hit || res_free : 1'b0;
            if (in_cap && !done_reg)
            begin
                unique case (req_t'(type_reg))
                    REQ_CREATE, REQ_QUEUE: cmd.wr_new = !h.used;
                    REQ_ENABLE: cmd.wr_en  = h.used && pos_reg[grp_reg] == tgt_reg;
                    REQ_REMOVE: cmd.wr_rem = h.used && pos_reg[grp_reg] == tgt_reg;
                    REQ_PROCESS: cmd.fire  = hit && res_free;
                    default: cmd.shift = cmd.shift;
                endcase
            end
            // A write at the head lands this cycle; the ring turns next cycle.
            if (cmd.wr_new || cmd.wr_en || cmd.wr_rem || cmd.fire)
                cmd.shift = 1'b0;
        end
    end

    assign req.ready = state_reg == S_IDLE && res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            proc_en_reg <= 1'b0;
            ov_reg      <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                cap_reg[g]  <= '0;
                last_reg[g] <= NONE_SLOT;
                pos_reg[g]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // Configuration writes.
            if (cfg_we)
            begin
                if (cfg_index == CFG_ENABLE)
                    proc_en_reg <= cfg_data[0];
                else if (!proc_en_reg)
                begin
                    for (int g = 0; g < NUM_GROUPS; g++)
                        if (cfg_index == 3'(g + 1))
                            cap_reg[g] <= cfg_data;
                end
            end
            // Result valid: set when a result is loaded, cleared after its transfer.
            if (accept && state_next != S_SCAN)
                ov_reg <= 1'b1;
            else if (state_reg == S_SCAN && cmd.fire)
                ov_reg <= 1'b1;
            else if (state_reg == S_OUT && res_free)
                ov_reg <= 1'b1;
            else if (res.ready)
                ov_reg <= 1'b0;
            if (accept)
            begin
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            if (state_reg == S_SCAN)
            begin
                // A processed slot is handled once; the flag clears as it leaves the head.
                if (cmd.shift)
                begin
                    pos_reg[grp_reg] <= pos_reg[grp_reg] + 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (type_reg == REQ_PROCESS)
                        done_reg <= 1'b0;
                end
                if (cmd.wr_new || cmd.wr_en || cmd.wr_rem || cmd.fire)
                    done_reg <= 1'b1;
                if (cmd.fire)
                    last_reg[grp_reg] <= pos_ext;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            grp_reg   <= req.group_index;
            type_reg  <= req.req_type;
            tgt_reg   <= req.target_slot;
            now_reg   <= req.now_ms;
            ivl_reg   <= req.interval_ms;
            en_reg    <= req.enable_value;
            found_reg <= NONE_SLOT;
            ofired_reg <= 1'b0;
            olast_reg  <= 1'b1;
            oslot_reg  <= NONE_SLOT;
            ocur_reg   <= cur_in;
            if (req.req_type > REQ_REMOVE)
                ost_reg <= ST_OK;
            else if (req.req_type == REQ_PROCESS && !proc_en_reg)
                ost_reg <= ST_DISABLED;
            else if (cap_in == '0)
                ost_reg <= ST_ABSENT;
        end
        if (state_reg == S_SCAN)
        begin
            if (cmd.wr_new || cmd.wr_en || cmd.wr_rem)
                found_reg <= pos_ext;
            if (cmd.fire)
            begin
                ost_reg    <= ST_OK;
                oslot_reg  <= pos_ext;
                ofired_reg <= 1'b1;
                ocur_reg   <= pos_ext;
                olast_reg  <= 1'b0;
            end
        end
        if (state_reg == S_OUT && res_free)
        begin
            ofired_reg <= 1'b0;
            olast_reg  <= 1'b1;
            ocur_reg   <= cap_sat != '0 ? last_reg[grp_reg] : NONE_SLOT;
            unique case (req_t'(type_reg))
                REQ_PROCESS:
                begin
                    ost_reg   <= ST_OK;
                    oslot_reg <= NONE_SLOT;
                end
                REQ_CREATE, REQ_QUEUE:
                begin
                    ost_reg   <= found_reg == NONE_SLOT ? ST_FULL : ST_OK;
                    oslot_reg <= found_reg;
                end
                REQ_ENABLE, REQ_REMOVE:
                begin
                    ost_reg   <= found_reg == NONE_SLOT ? ST_EMPTY : ST_OK;
                    oslot_reg <= CW'(tgt_reg);
                end
                default:
                begin
                    ost_reg   <= ST_OK;
                    oslot_reg <= NONE_SLOT;
                end
            endcase
        end
    end

    assign res.valid        = ov_reg;
    assign res.status       = ost_reg;
    assign res.result_slot  = oslot_reg;
    assign res.fired        = ofired_reg;
    assign res.current_slot = ocur_reg;
    assign res.last         = olast_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cnt_reg < CW'(SLOTS))
        else $error("scan overran ring");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_new, cmd.wr_en, cmd.wr_rem, cmd.fire, cmd.shift}))
        else $error("conflicting cell commands");
    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |=> ov_reg && ofired_reg)
        else $error("fire without result");
`endif

endmodule

// File: rtl/grouped_soft_timer_scheduler_top.sv
// Grouped soft timer scheduler: four groups of up to sixteen timer slots, held
// in a ring of sixteen cells per group. Every accepted request other than an
// early error rotates the addressed group's ring one full turn, one slot per
// cycle except where a slot is written, a task fires or a result stalls; a new
// request is taken only once the turn and its final result are done. Errors
// caught on entry (unknown request, processing disabled, group absent) return
// their result without turning the ring. Results are delivered one at a time
// with last set on the final one; a stalled result holds the ring in place.
module grouped_soft_timer_scheduler_top
    import gsts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    gsts_req_if.sink    req,
    gsts_res_if.source  res
);

    cell_cmd_t cmd;
    slot_t     head [NUM_GROUPS];

    gsts_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head)
    );

    gsts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .cmd       (cmd),
        .req       (req),
        .res       (res)
    );

endmodule

// File: tb/sv/gsts_timer_model.sv
package gsts_timer_model;
    import gsts_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] result_slot;
        logic       fired;
        logic [4:0] current_slot;
        logic       last;
    } timer_res_t;

    // Scoreboard: keeps its own copy of the timer slots and checks results in order.
    class timer_scoreboard;
        bit              proc_en;
        bit [4:0]        cap_reg [NUM_GROUPS];
        bit              used    [NUM_GROUPS*SLOTS];
        bit              periodic[NUM_GROUPS*SLOTS];
        bit              enabled [NUM_GROUPS*SLOTS];
        bit              remove  [NUM_GROUPS*SLOTS];
        bit [31:0]       due     [NUM_GROUPS*SLOTS];
        bit [31:0]       period  [NUM_GROUPS*SLOTS];
        bit [4:0]        last_slot[NUM_GROUPS];
        timer_res_t      pending[$];
        int              errors;

        function new();
            proc_en = 0;
            errors = 0;
            foreach (cap_reg[g])
            begin
                cap_reg[g] = 0;
                last_slot[g] = NONE_SLOT;
            end
            foreach (used[i])
            begin
                used[i] = 0;
                periodic[i] = 0;
                enabled[i] = 0;
                remove[i] = 0;
                due[i] = 0;
                period[i] = 0;
            end
        endfunction

        function void write_reg(cfg_idx_t idx, bit [4:0] v);
            if (idx == CFG_ENABLE)
                proc_en = v[0];
            else if (!proc_en && idx <= CFG_CAP3)
                cap_reg[idx - CFG_CAP0] = v;
        endfunction

        function int group_size(int g);
            return (cap_reg[g] > SLOTS) ? SLOTS : cap_reg[g];
        endfunction

        // Slot index that the next create would take, or -1 when the group is full.
        function int free_slot(int g);
            int n;
            n = group_size(g);
            for (int i = 0; i < n; i++)
                if (!used[g*SLOTS+i])
                    return i;
            return -1;
        endfunction

        function void push(bit [2:0] st, bit [4:0] rs, bit f, bit [4:0] cs, bit l);
            timer_res_t r;
            r.status = st;
            r.result_slot = rs;
            r.fired = f;
            r.current_slot = cs;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void note_request(bit [2:0] rq, bit [1:0] g, bit [3:0] tgt,
                                   bit [31:0] now, bit [31:0] ivl, bit en);
            int       n;
            int       b;
            int       s;
            bit [4:0] cur;
            n = group_size(g);
            cur = (n != 0) ? last_slot[g] : NONE_SLOT;
            b = g * SLOTS;
            if (rq > REQ_REMOVE)
                push(ST_OK, NONE_SLOT, 0, cur, 1);
            else if (rq == REQ_PROCESS && !proc_en)
                push(ST_DISABLED, NONE_SLOT, 0, cur, 1);
            else if (n == 0)
                push(ST_ABSENT, NONE_SLOT, 0, NONE_SLOT, 1);
            else if (rq == REQ_CREATE || rq == REQ_QUEUE)
            begin
                s = free_slot(g);
                if (s < 0)
                    push(ST_FULL, NONE_SLOT, 0, cur, 1);
                else
                begin
                    used[b+s] = 1;
                    remove[b+s] = 0;
                    period[b+s] = ivl;
                    periodic[b+s] = (rq == REQ_CREATE);
                    enabled[b+s] = (rq == REQ_QUEUE);
                    due[b+s] = (rq == REQ_CREATE) ? 32'd0 : now + ivl;
                    push(ST_OK, 5'(s), 0, cur, 1);
                end
            end
            else if (rq == REQ_ENABLE || rq == REQ_REMOVE)
            begin
                if (tgt >= n || !used[b+tgt])
                    push(ST_EMPTY, 5'(tgt), 0, cur, 1);
                else
                begin
                    if (rq == REQ_ENABLE)
                        enabled[b+tgt] = en;
                    else
                        remove[b+tgt] = 1;
                    push(ST_OK, 5'(tgt), 0, cur, 1);
                end
            end
            else
            begin
                // Scan in slot order and fire every enabled task that is due.
                for (int i = 0; i < n; i++)
                begin
                    s = b + i;
                    if (used[s] && enabled[s] && now >= due[s])
                    begin
                        last_slot[g] = 5'(i);
                        if (periodic[s])
                        begin
                            due[s] = now + period[s];
                            if (remove[s])
                                used[s] = 0;
                        end
                        else
                            used[s] = 0;
                        push(ST_OK, 5'(i), 1, 5'(i), 0);
                    end
                end
                push(ST_OK, NONE_SLOT, 0, last_slot[g], 1);
            end
        endfunction

        function void check_result(timer_res_t got);
            timer_res_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: %p", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.result_slot !== exp_r.result_slot)
            begin
                $error("result_slot: expected %0d, got %0d", exp_r.result_slot,
                       got.result_slot);
                errors++;
            end
            if (got.fired !== exp_r.fired)
            begin
                $error("fired: expected %0d, got %0d", exp_r.fired, got.fired);
                errors++;
            end
            if (got.current_slot !== exp_r.current_slot)
            begin
                $error("current_slot: expected %0d, got %0d", exp_r.current_slot,
                       got.current_slot);
                errors++;
            end
            if (got.last !== exp_r.last)
            begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass
endpackage

// File: tb/sv/grouped_soft_timer_scheduler_top_test.sv
module grouped_soft_timer_scheduler_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gsts_pkg::*;
    import gsts_timer_model::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [4:0] cfg_data;

    gsts_req_if req ();
    gsts_res_if res ();

    grouped_soft_timer_scheduler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .res       (res.source)
    );

    timer_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit [31:0] clock_ms;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, checked at the rising edge.
    initial
    begin
        res.ready = 0;
        forever
        begin
            @(negedge clk);
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && res.valid && res.ready)
            board.check_result({res.status, res.result_slot, res.fired,
                                res.current_slot, res.last});

    task automatic write_cfg(cfg_idx_t idx, bit [4:0] v);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        board.write_reg(idx, v);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Wait until every expected result has been checked, with valid held low.
    task automatic drain();
        int n;
        n = 0;
        req.valid <= 0;
        while (board.pending.size() != 0 && n < 200000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (40) @(negedge clk);
    endtask

    // Valid stays high after a transfer until the next send or a drain takes it down.
    task automatic send(bit [2:0] rq, bit [1:0] g, bit [3:0] tgt,
                        bit [31:0] now, bit [31:0] ivl, bit en);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 0;
            @(negedge clk);
        end
        req.valid <= 1;
        req.req_type <= rq;
        req.group_index <= g;
        req.target_slot <= tgt;
        req.now_ms <= now;
        req.interval_ms <= ivl;
        req.enable_value <= en;
        do
            @(posedge clk);
        while (!req.ready);
        board.note_request(rq, g, tgt, now, ivl, en);
        @(negedge clk);
    endtask

    // Mostly well-formed traffic (create, queue, enable, remove, process) with time advancing.
    task automatic random_item();
        int        pick;
        bit [1:0]  g;
        bit [31:0] now;
        g = 2'($urandom_range(3));
        pick = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(40);
        now = ($urandom_range(19) == 0) ? $urandom() : clock_ms;
        if (pick < 15)
            send(REQ_CREATE, g, 0, now, $urandom_range(60), 1'($urandom()));
        else if (pick < 30)
            send(REQ_QUEUE, g, 0, now,
                 ($urandom_range(9) == 0) ? $urandom() : $urandom_range(80), 0);
        else if (pick < 62)
            send(REQ_PROCESS, g, 4'($urandom()), now, $urandom(), 1'($urandom()));
        else if (pick < 80)
            send(REQ_ENABLE, g, 4'($urandom_range(15)), now, $urandom(),
                 ($urandom_range(3) != 0));
        else if (pick < 92)
            send(REQ_REMOVE, g, 4'($urandom_range(15)), now, $urandom(), 0);
        else
            send(3'($urandom_range(7)), g, 4'($urandom()), $urandom(), $urandom(),
                 1'($urandom()));
    endtask

    task automatic set_caps(bit [4:0] c0, bit [4:0] c1, bit [4:0] c2, bit [4:0] c3);
        write_cfg(CFG_ENABLE, 0);
        write_cfg(CFG_CAP0, c0);
        write_cfg(CFG_CAP1, c1);
        write_cfg(CFG_CAP2, c2);
        write_cfg(CFG_CAP3, c3);
        write_cfg(CFG_ENABLE, 1);
    endtask

    initial
    begin
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clock_ms = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_ENABLE;
        cfg_data = 0;
        req.valid = 0;
        req.req_type = REQ_CREATE;
        req.group_index = 0;
        req.target_slot = 0;
        req.now_ms = 0;
        req.interval_ms = 0;
        req.enable_value = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: absent groups, disabled processing and an unknown request straight after reset.
        send(REQ_CREATE, 0, 0, 0, 5, 0);
        send(REQ_PROCESS, 1, 0, 0, 0, 0);
        send(3'd7, 2, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        drain();
        set_caps(5'd31, 5'd1, 5'd16, 5'd0);
        write_cfg(CFG_CAP3, 5'd3);
        send(REQ_CREATE, 1, 0, 0, 10, 0);
        send(REQ_QUEUE, 1, 0, 0, 10, 0);
        send(REQ_ENABLE, 1, 0, 0, 0, 1);
        send(REQ_ENABLE, 1, 4'hF, 0, 0, 1);
        send(REQ_REMOVE, 3, 0, 0, 0, 0);
        send(REQ_PROCESS, 1, 0, 32'hFFFF_FFFF, 0, 0);
        send(REQ_PROCESS, 1, 0, 0, 0, 0);
        send(REQ_REMOVE, 1, 0, 0, 0, 0);
        send(REQ_PROCESS, 1, 0, 32'hFFFF_FFF0, 0, 0);
        send(REQ_QUEUE, 3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send(REQ_QUEUE, 0, 0, 32'h8000_0000, 0, 0);
        send(REQ_PROCESS, 3, 0, 32'hFFFF_FFFE, 0, 0);
        send(REQ_PROCESS, 0, 0, 32'h8000_0000, 0, 0);
        send(3'd5, 0, 0, 0, 0, 0);
        send(3'd6, 3, 0, 0, 0, 0);
        // Fill group 2 completely, then one more to see it full.
        for (int i = 0; i < 17; i++)
            send(REQ_QUEUE, 2, 0, 0, 0, 0);
        send(REQ_PROCESS, 2, 0, 0, 0, 0);
        drain();

        // Random phases, each resizing the groups and using one of four idle patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 4)
                set_caps(5'd0, 5'd31, 5'd1, 5'd16);
            else
                set_caps(5'($urandom_range(31)), 5'($urandom_range(16)),
                         5'($urandom_range(6)), 5'($urandom_range(16)));
            // Turning processing off with no group resize lands here too.
            if (ph == 6)
                write_cfg(CFG_ENABLE, 0);
            for (int k = 0; k < 55; k++)
            begin
                random_item();
                if (k == 30)
                    drain();
            end
            drain();
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// File: grouped_soft_timer_scheduler_top.f
rtl/gsts_pkg.sv
rtl/gsts_if.sv
rtl/gsts_cell.sv
rtl/gsts_row.sv
rtl/gsts_ctrl.sv
rtl/grouped_soft_timer_scheduler_top.sv
tb/sv/gsts_timer_model.sv
tb/sv/grouped_soft_timer_scheduler_top_test.sv
